// ===== design/particle_in_sphere_matcher_top_defines.svh =====
// assertion helpers for the sphere matcher
`ifndef PARTICLE_IN_SPHERE_MATCHER_TOP_DEFINES_SVH
`define PARTICLE_IN_SPHERE_MATCHER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PISM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked on every rising clock edge outside reset
`define PISM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/pism_pkg.sv =====
`default_nettype none

package pism_pkg;

   // table geometry
   localparam int SPHERE_SLOTS = 64;
   localparam int ADDR_W       = (SPHERE_SLOTS > 1) ? $clog2(SPHERE_SLOTS) : 1;

   // field widths
   localparam int SLOT_W  = 6;
   localparam int IDX_W   = 7;
   localparam int COORD_W = 32;
   localparam int RAD_W   = 31;
   localparam int CSR_A_W = 2;

   // request kinds
   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_QUERY = 1'b1
   } pism_req_kind_type;

   // register indexes
   typedef enum logic [CSR_A_W-1:0] {
      CSR_ID_LOW  = 2'd0,
      CSR_ID_HIGH = 2'd1
   } pism_csr_idx_type;

   // operand chosen for the shared squarer
   typedef enum logic [1:0] {
      SQ_R = 2'd0,
      SQ_X = 2'd1,
      SQ_Y = 2'd2,
      SQ_Z = 2'd3
   } pism_sq_sel_type;

   typedef struct packed {
      logic                      req_type;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_z;
      logic [RAD_W-1:0]          radius;
   } pism_req_type;

   typedef struct packed {
      logic [SLOT_W-1:0]         match_slot;
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic signed [COORD_W-1:0] out_z;
      logic                      last_match;
   } pism_rsp_type;

   // one sphere table entry
   typedef struct packed {
      logic signed [COORD_W-1:0] centre_x;
      logic signed [COORD_W-1:0] centre_y;
      logic signed [COORD_W-1:0] centre_z;
      logic [RAD_W-1:0]          sphere_radius;
   } pism_entry_type;

   localparam int ENTRY_W = $bits(pism_entry_type);

   // sequencer to distance unit
   typedef struct packed {
      logic            mag_en;
      logic            sq_en;
      pism_sq_sel_type sq_sel;
      logic            sum_en;
      logic            scale_en;
   } pism_dist_ctl_type;

endpackage

`default_nettype wire

// ===== design/pism_ram.sv =====
`default_nettype none

module pism_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/pism_dist_unit.sv =====
`default_nettype none

module pism_dist_unit (
   input  wire logic                               clock,
   input  wire pism_pkg::pism_dist_ctl_type        ctl,
   input  wire pism_pkg::pism_entry_type           entry,
   input  wire logic signed [pism_pkg::COORD_W-1:0] part_x,
   input  wire logic signed [pism_pkg::COORD_W-1:0] part_y,
   input  wire logic signed [pism_pkg::COORD_W-1:0] part_z,
   output logic                                    hit
);

   import pism_pkg::*;

   localparam int PROD_W = 2 * COORD_W;
   localparam int ACC_W  = PROD_W + 2;
   localparam int CMP_W  = ACC_W + 7;

   logic [COORD_W-1:0] mx_ff, my_ff, mz_ff, mr_ff;
   logic [COORD_W-1:0] sq_op;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PROD_W-1:0]  rsq_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [CMP_W-1:0]   lhs_ff, rhs_ff, lhs_in, rhs_in;

   // magnitude of a - b, which always fits in COORD_W bits
   function automatic logic [COORD_W-1:0] abs_diff(input logic signed [COORD_W-1:0] a,
                                                    input logic signed [COORD_W-1:0] b);
      logic signed [COORD_W:0] d;
      logic [COORD_W:0]        m;
      d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
      m = d[COORD_W] ? (~d + 1'b1) : d;
      return m[COORD_W-1:0];
   endfunction

   // per-axis magnitudes and radius
   always_ff @(posedge clock) begin
      if (ctl.mag_en) begin
         mx_ff <= abs_diff(entry.centre_x, part_x);
         my_ff <= abs_diff(entry.centre_y, part_y);
         mz_ff <= abs_diff(entry.centre_z, part_z);
         mr_ff <= {1'b0, entry.sphere_radius};
      end
   end

   // shared squarer operand select
   always_comb begin
      case (ctl.sq_sel)
         SQ_R:    sq_op = mr_ff;
         SQ_X:    sq_op = mx_ff;
         SQ_Y:    sq_op = my_ff;
         SQ_Z:    sq_op = mz_ff;
         default: sq_op = mr_ff;
      endcase
   end

   assign prod_in = PROD_W'(sq_op) * PROD_W'(sq_op);

   // scale by 100 = 64+32+4 and by 169 = 128+32+8+1
   assign lhs_in = (CMP_W'(acc_ff) << 6) + (CMP_W'(acc_ff) << 5) + (CMP_W'(acc_ff) << 2);
   assign rhs_in = (CMP_W'(rsq_ff) << 7) + (CMP_W'(rsq_ff) << 5) + (CMP_W'(rsq_ff) << 3)
                 + CMP_W'(rsq_ff);

   // squarer output, radius square and sum of squares
   always_ff @(posedge clock) begin
      if (ctl.sq_en) begin
         prod_ff <= prod_in;
         case (ctl.sq_sel)
            SQ_X:    rsq_ff <= prod_ff;
            SQ_Y:    acc_ff <= ACC_W'(prod_ff);
            SQ_Z:    acc_ff <= acc_ff + ACC_W'(prod_ff);
            default: ;
         endcase
      end else if (ctl.sum_en) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctl.scale_en) begin
         lhs_ff <= lhs_in;
         rhs_ff <= rhs_in;
      end
   end

   assign hit = (lhs_ff < rhs_ff);

endmodule

`default_nettype wire

// ===== design/particle_in_sphere_matcher_top.sv =====
// Sphere membership matcher.
// Request channel: an item is taken when start is high and busy is low.
// A load (req_type 0) writes one sphere slot and returns
// nothing; busy stays low, so the next item may follow at once.
// A query (req_type 1) raises busy and walks the slots from id_low up to,
// but not including, id_high (clipped to the table size). A slot that is
// not loaded is passed over; a loaded slot goes through table read, difference,
// four passes through the one shared 32x32 squarer, sum, scale and compare.
// Each match comes out as a one-cycle beat on rsp_valid with rsp_data; a
// match is held back until the next one is found, so the final beat of a
// query carries last_match. A query with no match gives no beat.
// The receiver cannot stall; beats never come back to back.
// Config writes (csr_) are always ready and meant for idle periods only.
// Reset clears all loaded marks and sets id_low 0, id_high 64; table
// contents are not cleared and are only read for loaded slots.
`default_nettype none

`include "particle_in_sphere_matcher_top_defines.svh"

module particle_in_sphere_matcher_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire pism_pkg::pism_req_type         req_data,
   output logic                                rsp_valid,
   output pism_pkg::pism_rsp_type              rsp_data,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [pism_pkg::CSR_A_W-1:0]   csr_index,
   input  wire logic [pism_pkg::IDX_W-1:0]     csr_wdata
);

   import pism_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_FETCH = 8'b0000_0010,
      ST_DIFF  = 8'b0000_0100,
      ST_MUL   = 8'b0000_1000,
      ST_SUM   = 8'b0001_0000,
      ST_SCALE = 8'b0010_0000,
      ST_CMP   = 8'b0100_0000,
      ST_FLUSH = 8'b1000_0000
   } pism_state_type;

   pism_state_type             state_ff, state_in;
   pism_sq_sel_type            step_ff, step_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [IDX_W-1:0]           id_low_ff, id_high_ff;
   logic [SPHERE_SLOTS-1:0]    valid_ff, valid_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0]          pend_slot_ff, pend_slot_in;
   logic signed [COORD_W-1:0]  px_ff, py_ff, pz_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   pism_rsp_type               rsp_data_ff, rsp_data_in;
   pism_dist_ctl_type          ctl;
   pism_entry_type             ram_wdata, ram_rdata;
   logic                       ram_wr_en, ram_rd_en;
   logic                       query_go, slot_ok, scan_done, hit;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign query_go  = start && !busy && (req_data.req_type == REQ_QUERY);
   assign slot_ok   = (IDX_W'(req_data.slot) < IDX_W'(SPHERE_SLOTS));
   assign scan_done = (j_ff >= id_high_ff) || (j_ff >= IDX_W'(SPHERE_SLOTS));

   assign ram_wdata = '{centre_x:      req_data.pos_x,
                        centre_y:      req_data.pos_y,
                        centre_z:      req_data.pos_z,
                        sphere_radius: req_data.radius};

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         id_low_ff  <= '0;
         id_high_ff <= IDX_W'(SPHERE_SLOTS);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ID_LOW:  id_low_ff  <= csr_wdata;
            CSR_ID_HIGH: id_high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      j_in          = j_ff;
      valid_in      = valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      rsp_valid_in  = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ctl           = '0;
      ctl.sq_sel    = step_ff;
      ram_wr_en     = 1'b0;
      ram_rd_en     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_go) begin
               j_in     = id_low_ff;
               state_in = ST_FETCH;
            end else if (start && slot_ok) begin
               ram_wr_en = 1'b1;
               valid_in[req_data.slot[ADDR_W-1:0]] = 1'b1;
            end
         end
         ST_FETCH: begin
            if (scan_done) begin
               state_in = ST_FLUSH;
            end else if (valid_ff[j_ff[ADDR_W-1:0]]) begin
               ram_rd_en = 1'b1;
               state_in  = ST_DIFF;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DIFF: begin
            ctl.mag_en = 1'b1;
            step_in    = SQ_R;
            state_in   = ST_MUL;
         end
         ST_MUL: begin
            ctl.sq_en = 1'b1;
            if (step_ff == SQ_Z) begin
               state_in = ST_SUM;
            end else begin
               step_in = pism_sq_sel_type'(step_ff + 2'd1);
            end
         end
         ST_SUM: begin
            ctl.sum_en = 1'b1;
            state_in   = ST_SCALE;
         end
         ST_SCALE: begin
            ctl.scale_en = 1'b1;
            state_in     = ST_CMP;
         end
         ST_CMP: begin
            // a new match releases the one held before it
            if (hit) begin
               if (pend_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{match_slot: pend_slot_ff, out_x: px_ff, out_y: py_ff,
                                   out_z: pz_ff, last_match: 1'b0};
               end
               pend_valid_in = 1'b1;
               pend_slot_in  = j_ff[SLOT_W-1:0];
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_FETCH;
         end
         ST_FLUSH: begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{match_slot: pend_slot_ff, out_x: px_ff, out_y: py_ff,
                                out_z: pz_ff, last_match: 1'b1};
            end
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= SQ_R;
         j_ff          <= '0;
         valid_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         j_ff          <= j_in;
         valid_ff      <= valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      rsp_data_ff  <= rsp_data_in;
      if (query_go) begin
         px_ff <= req_data.pos_x;
         py_ff <= req_data.pos_y;
         pz_ff <= req_data.pos_z;
      end
   end

   // sphere table
   pism_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SPHERE_SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_data.slot[ADDR_W-1:0]),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd_en),
      .rd_addr (j_ff[ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   // shared distance unit
   pism_dist_unit u_dist (
      .clock  (clock),
      .ctl    (ctl),
      .entry  (ram_rdata),
      .part_x (px_ff),
      .part_y (py_ff),
      .part_z (pz_ff),
      .hit    (hit)
   );

   // checks
   `PISM_ASSERT_NEXT(a_beat_spacing, rsp_valid_ff, !rsp_valid_ff, "back-to-back result beats")
   `PISM_ASSERT_NOW(a_last_drains, rsp_valid_ff && rsp_data_ff.last_match, !pend_valid_ff, "match held after last beat")
   `PISM_ASSERT_NOW(a_mid_holds, rsp_valid_ff && !rsp_data_ff.last_match, pend_valid_ff, "non-final beat without a held match")
   `PISM_ASSERT_NEXT(a_query_busy, query_go, busy, "query accepted but block not busy")

endmodule

`default_nettype wire

// ===== dv/particle_in_sphere_matcher_top_tb.sv =====
`timescale 1ns / 100ps

module particle_in_sphere_matcher_top_tb;
   import pism_pkg::*;

   localparam int SETTLE_CYCLES = 700;
   localparam int STALL_LIMIT   = 5000;
   localparam int PHASES        = 7;
   localparam int PHASE_ITEMS   = 64;
   localparam int MAX_REPORTS   = 10;

   localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;
   localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
   localparam logic [RAD_W-1:0]   R_MAX = 31'h7FFF_FFFF;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             start     = 1'b0;
   logic             busy;
   pism_req_type     req_data  = '0;
   logic             rsp_valid;
   pism_rsp_type     rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   pism_csr_idx_type csr_index = CSR_ID_LOW;
   logic [IDX_W-1:0] csr_wdata = '0;

   // range settings per phase; the first phase runs on the reset values
   int unsigned phase_low  [PHASES] = '{0, 5, 63, 0, 40, 0, 1};
   int unsigned phase_high [PHASES] = '{64, 40, 127, 127, 10, 0, 63};
   int unsigned phase_idle [PHASES] = '{34, 34, 34, 80, 80, 0, 0};

   // predicted sphere table and range, updated on accepted beats
   pism_entry_type sphere_tbl    [SPHERE_SLOTS];
   bit             sphere_loaded [SPHERE_SLOTS];
   int unsigned    range_low  = 0;
   int unsigned    range_high = 64;

   // table as planned by the stimulus, ahead of the block
   pism_entry_type plan_tbl    [SPHERE_SLOTS];
   bit             plan_loaded [SPHERE_SLOTS];

   pism_req_type pend_q  [$];
   pism_rsp_type match_q [$];
   int unsigned  sender_idle_pct = 34;
   int           fail_count      = 0;
   int           stall_cycles    = 0;

   particle_in_sphere_matcher_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #6 clock = ~clock;

   // exact squared test: 100 * d^2 < 169 * r^2 at 80 bits
   function automatic bit sphere_holds(int j, pism_req_type q);
      logic signed [COORD_W+1:0] d [3];
      logic [COORD_W+1:0]        m;
      logic [79:0]               lhs;
      logic [79:0]               rhs;
      lhs  = '0;
      d[0] = {{2{sphere_tbl[j].centre_x[COORD_W-1]}}, sphere_tbl[j].centre_x}
             - {{2{q.pos_x[COORD_W-1]}}, q.pos_x};
      d[1] = {{2{sphere_tbl[j].centre_y[COORD_W-1]}}, sphere_tbl[j].centre_y}
             - {{2{q.pos_y[COORD_W-1]}}, q.pos_y};
      d[2] = {{2{sphere_tbl[j].centre_z[COORD_W-1]}}, sphere_tbl[j].centre_z}
             - {{2{q.pos_z[COORD_W-1]}}, q.pos_z};
      for (int k = 0; k < 3; k++) begin
         m   = d[k][COORD_W+1] ? -d[k] : d[k];
         lhs = lhs + 80'(m) * 80'(m) * 80'd100;
      end
      rhs = 80'(sphere_tbl[j].sphere_radius) * 80'(sphere_tbl[j].sphere_radius) * 80'd169;
      return lhs < rhs;
   endfunction

   // apply one accepted beat: loads update the table, queries queue their matches
   function automatic void predict_matches(pism_req_type q);
      pism_rsp_type hit;
      bit           have;
      have = 1'b0;
      hit  = '0;
      if (q.req_type == REQ_LOAD) begin
         sphere_tbl[q.slot].centre_x      = q.pos_x;
         sphere_tbl[q.slot].centre_y      = q.pos_y;
         sphere_tbl[q.slot].centre_z      = q.pos_z;
         sphere_tbl[q.slot].sphere_radius = q.radius;
         sphere_loaded[q.slot]            = 1'b1;
      end else begin
         for (int j = 0; j < SPHERE_SLOTS; j++) begin
            if (sphere_loaded[j] && j >= range_low && j < range_high && sphere_holds(j, q)) begin
               // the previous hit is not the last one
               if (have)
                  match_q.push_back(hit);
               hit.match_slot = SLOT_W'(j);
               hit.out_x      = q.pos_x;
               hit.out_y      = q.pos_y;
               hit.out_z      = q.pos_z;
               hit.last_match = 1'b0;
               have           = 1'b1;
            end
         end
         if (have) begin
            hit.last_match = 1'b1;
            match_q.push_back(hit);
         end
      end
   endfunction

   function automatic void queue_item(pism_req_kind_type kind, logic [SLOT_W-1:0] slot,
                                      logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                      logic [COORD_W-1:0] z, logic [RAD_W-1:0] r);
      pism_req_type it;
      it.req_type = kind;
      it.slot     = slot;
      it.pos_x    = x;
      it.pos_y    = y;
      it.pos_z    = z;
      it.radius   = r;
      if (kind == REQ_LOAD) begin
         plan_tbl[slot].centre_x      = x;
         plan_tbl[slot].centre_y      = y;
         plan_tbl[slot].centre_z      = z;
         plan_tbl[slot].sphere_radius = r;
         plan_loaded[slot]            = 1'b1;
      end
      pend_q.push_back(it);
   endfunction

   // loads into a cluster, queries around loaded spheres, and some noise
   function automatic void plan_random_item();
      int unsigned        pick;
      int                 j;
      longint             lim;
      logic [COORD_W-1:0] c [3];
      logic [RAD_W-1:0]   r;
      int                 loaded_slots [$];
      pick = $urandom_range(99);
      for (int s = 0; s < SPHERE_SLOTS; s++)
         if (plan_loaded[s])
            loaded_slots.push_back(s);
      if (pick < 30 || loaded_slots.size() == 0) begin
         for (int k = 0; k < 3; k++)
            c[k] = ($urandom_range(99) < 85) ? $urandom_range(0, 2**23) - 2**22 : $urandom();
         pick = $urandom_range(99);
         if (pick < 10)
            r = '0;
         else if (pick < 20)
            r = RAD_W'($urandom());
         else
            r = RAD_W'($urandom_range(1, 2**22));
         queue_item(REQ_LOAD, SLOT_W'($urandom_range(63)), c[0], c[1], c[2], r);
      end else if (pick < 85) begin
         // offsets up to 4/5 r per axis put the point on both sides of 1.3 r
         j   = loaded_slots[$urandom_range(loaded_slots.size() - 1)];
         lim = longint'(plan_tbl[j].sphere_radius) * 4 / 5;
         c[0] = COORD_W'(longint'(plan_tbl[j].centre_x)
                + longint'($urandom_range(0, 32'(2 * lim))) - lim);
         c[1] = COORD_W'(longint'(plan_tbl[j].centre_y)
                + longint'($urandom_range(0, 32'(2 * lim))) - lim);
         c[2] = COORD_W'(longint'(plan_tbl[j].centre_z)
                + longint'($urandom_range(0, 32'(2 * lim))) - lim);
         queue_item(REQ_QUERY, SLOT_W'($urandom_range(63)), c[0], c[1], c[2],
                    RAD_W'($urandom()));
      end else begin
         queue_item(REQ_QUERY, SLOT_W'($urandom_range(63)), $urandom(), $urandom(),
                    $urandom(), RAD_W'($urandom()));
      end
   endfunction

   // wait until every beat is taken and every match has come, then let the block settle
   task automatic drain_block();
      do
         @(negedge clock);
      while (pend_q.size() != 0 || start || busy !== 1'b0 || match_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // both range registers, back to back on the csr channel
   task automatic write_range(int unsigned lo, int unsigned hi);
      csr_valid <= 1'b1;
      csr_index <= CSR_ID_LOW;
      csr_wdata <= IDX_W'(lo);
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      range_low = lo;
      csr_index <= CSR_ID_HIGH;
      csr_wdata <= IDX_W'(hi);
      do
         @(posedge clock);
      while (csr_ready !== 1'b1);
      range_high = hi;
      csr_valid <= 1'b0;
   endtask

   // request driver: hold a beat while busy, idle at random between beats
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy)
            predict_matches(req_data);
         if (!start || !busy) begin
            if (pend_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               req_data <= pend_q.pop_front();
               start    <= 1'b1;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // match monitor: every beat against the oldest expected match
   always @(posedge clock) begin
      pism_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (match_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("%0t: unexpected match beat, slot %0d xyz %h %h %h last %b", $realtime,
                        rsp_data.match_slot, rsp_data.out_x, rsp_data.out_y, rsp_data.out_z,
                        rsp_data.last_match);
         end else begin
            want = match_q.pop_front();
            if (rsp_data.match_slot !== want.match_slot || rsp_data.out_x !== want.out_x ||
                rsp_data.out_y !== want.out_y || rsp_data.out_z !== want.out_z ||
                rsp_data.last_match !== want.last_match) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $display("%0t: match mismatch, expected slot %0d xyz %h %h %h last %b",
                           $realtime, want.match_slot, want.out_x, want.out_y, want.out_z,
                           want.last_match);
                  $display("%0t: match mismatch, got slot %0d xyz %h %h %h last %b",
                           $realtime, rsp_data.match_slot, rsp_data.out_x, rsp_data.out_y,
                           rsp_data.out_z, rsp_data.last_match);
               end
            end
         end
      end
   end

   // watchdog on cycles with no beat on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid === 1'b1 || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // boundary: 100 * 13^2 equals 169 * 10^2, so 13 is outside and 12 inside
      queue_item(REQ_LOAD, 0, 0, 0, 0, 10);
      queue_item(REQ_QUERY, 0, 13, 0, 0, 0);
      queue_item(REQ_QUERY, 0, 12, 0, 0, 0);
      queue_item(REQ_QUERY, 0, 0, 0, -12, 0);
      // opposite corners of the coordinate range with the widest radius
      queue_item(REQ_LOAD, 63, C_MIN, C_MIN, C_MIN, R_MAX);
      queue_item(REQ_QUERY, 63, C_MAX, C_MIN, C_MIN, R_MAX);
      queue_item(REQ_QUERY, 0, 0, C_MIN, C_MIN, 0);
      // zero radius never holds a point, not even its own centre
      queue_item(REQ_LOAD, 1, 0, 0, 0, 0);
      queue_item(REQ_LOAD, 2, 5, 5, 5, 1000);
      queue_item(REQ_QUERY, 63, 0, 0, 0, 0);
      // nothing in reach
      queue_item(REQ_QUERY, 21, 32'h4000_0000, 32'h4000_0000, 32'h4000_0000, 0);
      // reload a slot and hit the far corner
      queue_item(REQ_LOAD, 0, C_MAX, C_MAX, C_MAX, R_MAX);
      queue_item(REQ_QUERY, 42, C_MAX, C_MAX, C_MAX, 31'h2AAA_AAAA);
      queue_item(REQ_QUERY, 0, 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, R_MAX);
      queue_item(REQ_LOAD, 31, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000, 31'h5555_5555);
      queue_item(REQ_QUERY, 0, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_1234, 0);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            drain_block();
            write_range(phase_low[p], phase_high[p]);
            @(negedge clock);
         end
         sender_idle_pct = phase_idle[p];
         for (int n = 0; n < PHASE_ITEMS; n++)
            plan_random_item();
      end

      drain_block();
      if (match_q.size() != 0) begin
         fail_count += match_q.size();
         $display("%0d expected match beats never arrived", match_q.size());
      end
      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/pism_pkg.sv
design/pism_ram.sv
design/pism_dist_unit.sv
design/particle_in_sphere_matcher_top.sv
dv/particle_in_sphere_matcher_top_tb.sv
